[rtl/msq_pkg.sv]
// Shared types, tables and widths for the marching squares cell pipeline.
`default_nettype none
package msq_pkg;

  localparam int NUM_EDGES  = 4;
  localparam int NUM_LANES  = 2 * NUM_EDGES;
  localparam int DIV_STAGES = 16;
  localparam int NUM_STAGES = DIV_STAGES + 3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  typedef struct packed {
    logic [1:0] s;
    logic [1:0] e;
  } seg_t;

  typedef struct packed {
    logic [3:0]               idx;
    point_t [NUM_EDGES-1:0]   pa;
    logic [NUM_EDGES-1:0]     neg_x;
    logic [NUM_EDGES-1:0]     neg_y;
    logic [NUM_EDGES-1:0]     den_zero;
  } side_t;

  function automatic logic [3:0] crossed_edges(input logic [3:0] idx);
    logic [3:0] m;
    unique case (idx)
      4'd0:    m = 4'd0;
      4'd1:    m = 4'd9;
      4'd2:    m = 4'd3;
      4'd3:    m = 4'd10;
      4'd4:    m = 4'd6;
      4'd5:    m = 4'd15;
      4'd6:    m = 4'd5;
      4'd7:    m = 4'd12;
      4'd8:    m = 4'd12;
      4'd9:    m = 4'd5;
      4'd10:   m = 4'd15;
      4'd11:   m = 4'd6;
      4'd12:   m = 4'd10;
      4'd13:   m = 4'd3;
      4'd14:   m = 4'd9;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] seg_count(input logic [3:0] idx);
    logic [1:0] n;
    unique case (idx)
      4'd0, 4'd15: n = 2'd0;
      4'd5, 4'd10: n = 2'd2;
      default:     n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic seg_t seg_edge(input logic [3:0] idx, input logic second);
    seg_t r;
    unique case (idx)
      4'd1, 4'd14: r = '{s: 2'd0, e: 2'd3};
      4'd2, 4'd13: r = '{s: 2'd0, e: 2'd1};
      4'd3, 4'd12: r = '{s: 2'd1, e: 2'd3};
      4'd4, 4'd11: r = '{s: 2'd1, e: 2'd2};
      4'd5:        r = second ? '{s: 2'd1, e: 2'd2} : '{s: 2'd0, e: 2'd3};
      4'd6, 4'd9:  r = '{s: 2'd0, e: 2'd2};
      4'd7, 4'd8:  r = '{s: 2'd2, e: 2'd3};
      4'd10:       r = second ? '{s: 2'd2, e: 2'd3} : '{s: 2'd0, e: 2'd1};
      default:     r = '{s: 2'd0, e: 2'd0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/msq_ifs.sv]
// Valid/ready channel interfaces for cell words and segment words.
`default_nettype none
interface msq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value_0;
  logic signed [15:0] value_1;
  logic signed [15:0] value_2;
  logic signed [15:0] value_3;
  logic signed [15:0] pos_x_0;
  logic signed [15:0] pos_y_0;
  logic signed [15:0] pos_x_1;
  logic signed [15:0] pos_y_1;
  logic signed [15:0] pos_x_2;
  logic signed [15:0] pos_y_2;
  logic signed [15:0] pos_x_3;
  logic signed [15:0] pos_y_3;

  modport source (
    output valid, value_0, value_1, value_2, value_3,
    output pos_x_0, pos_y_0, pos_x_1, pos_y_1, pos_x_2, pos_y_2, pos_x_3, pos_y_3,
    input  ready
  );
  modport sink (
    input  valid, value_0, value_1, value_2, value_3,
    input  pos_x_0, pos_y_0, pos_x_1, pos_y_1, pos_x_2, pos_y_2, pos_x_3, pos_y_3,
    output ready
  );
endinterface

interface msq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic               last_segment;

  modport source (
    output valid, start_x, start_y, end_x, end_y, last_segment,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, last_segment,
    output ready
  );
endinterface
`default_nettype wire

[rtl/msq_front.sv]
// Front stages: case index, edge differences, magnitudes and products.
`default_nettype none
module msq_front
  import msq_pkg::*;
(
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [15:0]          iso,
  input  logic signed [15:0]          val [NUM_EDGES],
  input  point_t                      pos [NUM_EDGES],
  output logic [31:0]                 num [NUM_LANES],
  output logic [15:0]                 den [NUM_LANES],
  output side_t                       side
);

  function automatic logic [15:0] abs17(input logic signed [16:0] v);
    logic [16:0] n;
    n = v[16] ? 17'(-v) : 17'(v);
    return n[15:0];
  endfunction

  logic [15:0] dn_a  [NUM_EDGES];
  logic [15:0] dv_a  [NUM_EDGES];
  logic [15:0] dpx_a [NUM_EDGES];
  logic [15:0] dpy_a [NUM_EDGES];
  side_t       side_a;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_EDGES; k++) begin
        logic signed [16:0] dn, dv, dpx, dpy;
        dn  = 17'(iso) - 17'(val[k]);
        dv  = 17'(val[(k + 1) % NUM_EDGES]) - 17'(val[k]);
        dpx = 17'(pos[(k + 1) % NUM_EDGES].x) - 17'(pos[k].x);
        dpy = 17'(pos[(k + 1) % NUM_EDGES].y) - 17'(pos[k].y);
        dn_a[k]             <= abs17(dn);
        dv_a[k]             <= abs17(dv);
        dpx_a[k]            <= abs17(dpx);
        dpy_a[k]            <= abs17(dpy);
        side_a.neg_x[k]     <= dn[16] ^ dpx[16] ^ dv[16];
        side_a.neg_y[k]     <= dn[16] ^ dpy[16] ^ dv[16];
        side_a.den_zero[k]  <= (dv == 17'sd0);
        side_a.pa[k]        <= pos[k];
        side_a.idx[k]       <= (val[k] < iso);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_EDGES; k++) begin
        num[2*k]     <= 32'(dn_a[k]) * 32'(dpx_a[k]);
        num[2*k + 1] <= 32'(dn_a[k]) * 32'(dpy_a[k]);
        den[2*k]     <= dv_a[k];
        den[2*k + 1] <= dv_a[k];
      end
      side <= side_a;
    end
  end

endmodule
`default_nettype wire

[rtl/msq_div_lane.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module msq_div_lane
  import msq_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic [15:0] quo
);

  logic [15:0] rem_s [DIV_STAGES+1];
  logic [15:0] lo_s  [DIV_STAGES+1];
  logic [15:0] q_s   [DIV_STAGES+1];
  logic [15:0] den_s [DIV_STAGES+1];

  assign rem_s[0] = num[31:16];
  assign lo_s[0]  = num[15:0];
  assign q_s[0]   = '0;
  assign den_s[0] = den;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [16:0] t;
    logic [17:0] d;
    logic        ge;
    assign t  = {rem_s[j], lo_s[j][15]};
    assign d  = {1'b0, t} - {2'b00, den_s[j]};
    assign ge = ~d[17];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j+1] <= ge ? d[15:0] : t[15:0];
        lo_s[j+1]  <= {lo_s[j][14:0], 1'b0};
        q_s[j+1]   <= {q_s[j][14:0], ge};
        den_s[j+1] <= den_s[j];
      end
    end
  end

  assign quo = q_s[DIV_STAGES];

endmodule
`default_nettype wire

[rtl/msq_emit.sv]
// Segment emitter: walks the line table of a finished cell, one segment per word.
`default_nettype none
module msq_emit
  import msq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fin_valid,
  input  logic [3:0]             fin_idx,
  input  point_t [NUM_EDGES-1:0] fin_pts,
  output logic                   fin_ready,
  msq_out_if.source              out_ch
);

  logic                   hold_v;
  logic                   phase;
  logic [3:0]             idx;
  point_t [NUM_EDGES-1:0] pts;

  logic [1:0] nseg;
  logic       last;
  logic       done;
  seg_t       seg;

  assign nseg      = seg_count(idx);
  assign last      = (nseg == 2'd1) || phase;
  assign done      = hold_v && ((nseg == 2'd0) || (out_ch.ready && last));
  assign fin_ready = ~hold_v || done;
  assign seg       = seg_edge(idx, phase);

  assign out_ch.valid        = hold_v && (nseg != 2'd0);
  assign out_ch.start_x      = pts[seg.s].x;
  assign out_ch.start_y      = pts[seg.s].y;
  assign out_ch.end_x        = pts[seg.e].x;
  assign out_ch.end_y        = pts[seg.e].y;
  assign out_ch.last_segment = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      phase  <= 1'b0;
    end else if (fin_valid && fin_ready) begin
      hold_v <= 1'b1;
      phase  <= 1'b0;
    end else if (done) begin
      hold_v <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      idx <= fin_idx;
      pts <= fin_pts;
    end
  end

endmodule
`default_nettype wire

[rtl/marching_squares_cell.sv]
// Marching squares cell: one cell word in, zero to two segment words out. The pipeline
// accepts a cell every cycle while it is not held, and has 19 register stages (2 front, 16
// divider, 1 finish) before the segment emitter register, from which the segment words go out.
// The emitter sends one segment word per cycle while the output side is ready: saddle
// cells occupy it for two words, other cells for one; empty cells still pass through it
// but send no word. The whole pipeline holds while a finished cell waits for the emitter.
// The isovalue is written through cfg_we/cfg_data and must only change while no
// cell is in flight.
`default_nettype none
module marching_squares_cell
  import msq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  msq_in_if.sink      in_ch,
  msq_out_if.source   out_ch
);

  logic signed [15:0]     iso;
  logic [NUM_STAGES-1:0]  v;
  logic                   en;
  logic                   emit_ready;

  logic signed [15:0] val [NUM_EDGES];
  point_t             pos [NUM_EDGES];
  logic [31:0]        num [NUM_LANES];
  logic [15:0]        den [NUM_LANES];
  logic [15:0]        quo [NUM_LANES];
  side_t              side_b;
  side_t              side_d [DIV_STAGES];

  logic [3:0]             fin_idx;
  point_t [NUM_EDGES-1:0] fin_pts;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso <= '0;
    end else if (cfg_we) begin
      iso <= cfg_data;
    end
  end

  assign en          = ~v[NUM_STAGES-1] || emit_ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NUM_STAGES-2:0], in_ch.valid};
    end
  end

  assign val[0] = in_ch.value_0;
  assign val[1] = in_ch.value_1;
  assign val[2] = in_ch.value_2;
  assign val[3] = in_ch.value_3;
  assign pos[0] = '{x: in_ch.pos_x_0, y: in_ch.pos_y_0};
  assign pos[1] = '{x: in_ch.pos_x_1, y: in_ch.pos_y_1};
  assign pos[2] = '{x: in_ch.pos_x_2, y: in_ch.pos_y_2};
  assign pos[3] = '{x: in_ch.pos_x_3, y: in_ch.pos_y_3};

  msq_front u_front (
    .clk  (clk),
    .en   (en),
    .iso  (iso),
    .val  (val),
    .pos  (pos),
    .num  (num),
    .den  (den),
    .side (side_b)
  );

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    msq_div_lane u_div (
      .clk (clk),
      .en  (en),
      .num (num[l]),
      .den (den[l]),
      .quo (quo[l])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_b;
      for (int j = 1; j < DIV_STAGES; j++) begin
        side_d[j] <= side_d[j-1];
      end
    end
  end

  function automatic logic signed [15:0] finish_coord(
    input logic signed [15:0] pa,
    input logic [15:0]        q,
    input logic               neg,
    input logic               zero
  );
    logic signed [17:0] qs;
    logic signed [17:0] r;
    qs = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (zero) qs = '0;
    r = 18'(pa) + qs;
    if (r > 18'sd32767) return 16'sh7fff;
    else if (r < -18'sd32768) return 16'sh8000;
    else return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      logic [3:0] crossed;
      crossed = crossed_edges(side_d[DIV_STAGES-1].idx);
      fin_idx <= side_d[DIV_STAGES-1].idx;
      for (int k = 0; k < NUM_EDGES; k++) begin
        if (crossed[k]) begin
          fin_pts[k].x <= finish_coord(side_d[DIV_STAGES-1].pa[k].x, quo[2*k],
                                       side_d[DIV_STAGES-1].neg_x[k],
                                       side_d[DIV_STAGES-1].den_zero[k]);
          fin_pts[k].y <= finish_coord(side_d[DIV_STAGES-1].pa[k].y, quo[2*k + 1],
                                       side_d[DIV_STAGES-1].neg_y[k],
                                       side_d[DIV_STAGES-1].den_zero[k]);
        end else begin
          fin_pts[k] <= '0;
        end
      end
    end
  end

  msq_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (v[NUM_STAGES-1]),
    .fin_idx   (fin_idx),
    .fin_pts   (fin_pts),
    .fin_ready (emit_ready),
    .out_ch    (out_ch)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> (v == '0))
    else $error("pipeline not empty after reset");

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (v[NUM_STAGES-1] && !en) |=> (v[NUM_STAGES-1] && $stable(fin_idx)))
    else $error("finished cell lost while emitter blocked");

  a_crossed_den: assert property (@(posedge clk) disable iff (rst)
    v[NUM_STAGES-2] |->
      ((crossed_edges(side_d[DIV_STAGES-1].idx) & side_d[DIV_STAGES-1].den_zero) == 4'd0))
    else $error("zero divisor on a crossed edge");

endmodule
`default_nettype wire
